[sv/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // window size register
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WIN_SIZE_RESET = CFG_W'(1);

endpackage

[sv/sliding_window_median.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: sample; s_tuser: start_of_sequence
// m_        out  m_tvalid/m_tready    m_tdata: median
// cfg_      in   cfg_valid/cfg_ready  cfg_data: window_size
//
// One word per cycle sustained while no result word is held; a sample's median passes
// through the input register, loaded at acceptance, and then the result register.
// The insert/select/remove on the flop-based sorted store is combinational.
// Synchronous active-low reset empties the window; window_size resets to 1.
// A held result only stalls the input side once the input register is full.

module sliding_window_median #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,  // sample
    input  logic                                    s_tuser,  // start_of_sequence
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,  // median
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]               cfg_data  // window_size
);

    import swm_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_MAX+1);
    localparam int DATA_W = ((SAMPLE_BITS+7)/8)*8;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_sos_reg;
    logic                          m_valid_reg;
    logic        [SAMPLE_BITS-1:0] m_data_reg;
    logic        [CNT_W-1:0]       win_size_reg, win_size_next;
    logic                          fire;
    logic                          emit;
    logic signed [SAMPLE_BITS-1:0] median;

    assign fire      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = DATA_W'(m_data_reg);
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            win_size_next = CNT_W'(1);
        end else if (int'(cfg_data) > WINDOW_MAX) begin
            win_size_next = CNT_W'(WINDOW_MAX);
        end else begin
            win_size_next = CNT_W'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= CNT_W'(WIN_SIZE_RESET);
        end else if (cfg_valid && cfg_ready) begin
            win_size_reg <= win_size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            in_sos_reg    <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_data_reg <= median;
        end
    end

    swm_core #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_i     (fire),
        .sample_i   (in_sample_reg),
        .restart_i  (in_sos_reg),
        .win_size_i (win_size_reg),
        .emit_o     (emit),
        .median_o   (median)
    );

    a_no_step_on_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !fire)
        else $error("step taken while result word is held");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit) |=> m_valid_reg)
        else $error("result word lost");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

    a_win_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (win_size_reg != '0) && (win_size_reg <= CNT_W'(WINDOW_MAX)))
        else $error("window size outside built depth");

endmodule

[sv/swm_core.sv]
`timescale 1ns / 1ps

module swm_core #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   step_i,
    input  logic signed [SAMPLE_BITS-1:0]          sample_i,
    input  logic                                   restart_i,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]        win_size_i,
    output logic                                   emit_o,
    output logic signed [SAMPLE_BITS-1:0]          median_o
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX+1);
    localparam int SUM_W = IDX_W + 1;

    // sorted store: value plus the ring slot it arrived in
    logic signed [SAMPLE_BITS-1:0] val_reg  [WINDOW_MAX];
    logic        [IDX_W-1:0]       tag_reg  [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] val_next [WINDOW_MAX];
    logic        [IDX_W-1:0]       tag_next [WINDOW_MAX];
    logic        [CNT_W-1:0]       fill_reg,   fill_next;
    logic        [IDX_W-1:0]       oldest_reg, oldest_next;

    logic signed [SAMPLE_BITS-1:0] ins_val [WINDOW_MAX];
    logic        [IDX_W-1:0]       ins_tag [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0]  le;
    logic        [WINDOW_MAX-1:0]  match;
    logic                          restart;
    logic        [CNT_W-1:0]       f0, f1;
    logic        [IDX_W-1:0]       o0, slot, rm_idx, med_idx;
    logic        [SUM_W-1:0]       slot_sum;

    always_comb begin
        restart  = restart_i || (fill_reg >= win_size_i);
        f0       = restart ? '0 : fill_reg;
        o0       = restart ? '0 : oldest_reg;
        f1       = f0 + CNT_W'(1);
        emit_o   = (f1 >= win_size_i);
        slot_sum = SUM_W'(o0) + SUM_W'(f0);
        if (slot_sum >= SUM_W'(WINDOW_MAX)) begin
            slot = IDX_W'(slot_sum - SUM_W'(WINDOW_MAX));
        end else begin
            slot = IDX_W'(slot_sum);
        end

        // entries at or below the new sample stay, the new one lands after them
        for (int i = 0; i < WINDOW_MAX; i++) begin
            le[i] = (CNT_W'(i) < f0) && (val_reg[i] <= sample_i);
        end
        if (le[0]) begin
            ins_val[0] = val_reg[0];
            ins_tag[0] = tag_reg[0];
        end else begin
            ins_val[0] = sample_i;
            ins_tag[0] = slot;
        end
        for (int i = 1; i < WINDOW_MAX; i++) begin
            if (le[i]) begin
                ins_val[i] = val_reg[i];
                ins_tag[i] = tag_reg[i];
            end else if (le[i-1]) begin
                ins_val[i] = sample_i;
                ins_tag[i] = slot;
            end else begin
                ins_val[i] = val_reg[i-1];
                ins_tag[i] = tag_reg[i-1];
            end
        end

        med_idx  = IDX_W'((win_size_i - CNT_W'(1)) >> 1);
        median_o = ins_val[med_idx];

        // oldest entry is the one tagged with the oldest slot (tags are unique)
        rm_idx = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            match[j] = (CNT_W'(j) < f1) && (ins_tag[j] == o0);
            if (match[j]) begin
                rm_idx = rm_idx | IDX_W'(j);
            end
        end

        for (int j = 0; j < WINDOW_MAX; j++) begin
            val_next[j] = ins_val[j];
            tag_next[j] = ins_tag[j];
        end
        if (emit_o) begin
            for (int j = 0; j < WINDOW_MAX - 1; j++) begin
                if (IDX_W'(j) >= rm_idx) begin
                    val_next[j] = ins_val[j+1];
                    tag_next[j] = ins_tag[j+1];
                end
            end
        end

        if (emit_o) begin
            fill_next = f0;
            if (o0 == IDX_W'(WINDOW_MAX - 1)) begin
                oldest_next = '0;
            end else begin
                oldest_next = o0 + IDX_W'(1);
            end
        end else begin
            fill_next   = f1;
            oldest_next = o0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_i) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                val_reg[i] <= val_next[i];
                tag_reg[i] <= tag_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end else if (step_i) begin
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < CNT_W'(WINDOW_MAX))
        else $error("fill count reached the store depth");

    a_oldest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg <= IDX_W'(WINDOW_MAX - 1))
        else $error("oldest slot out of range");

    a_emit_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_i && emit_o) |=> (fill_reg == $past(f0)))
        else $error("window did not drop its oldest sample after a result");

endmodule
